[rtl/btk_pkg.sv]
// Package for the bounded top-K score table.
// Holds the request, response and stored-entry types and the command codes.
// No dependencies.
package btk_pkg;

    localparam logic [1:0] CMD_SUBMIT = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] points;
        logic [31:0]        tag;
        logic [2:0]         read_index;
    } t_req;

    typedef struct packed {
        logic               accepted;
        logic               entry_valid;
        logic signed [31:0] entry_points;
        logic [31:0]        entry_tag;
        logic [3:0]         entry_count;
    } t_rsp;

    typedef struct packed {
        logic signed [31:0] score;
        logic [31:0]        tag;
    } t_entry;

endpackage

[rtl/bounded_top_k_sorted_insert.sv]
// Top level of the bounded top-K score table with sorted insertion.
// Depends on btk_pkg (types, command codes) and btk_ram (entry store).
//
//   channel   handshake             payload            direction
//   --------  --------------------  -----------------  ---------
//   request   start / busy          i_req  (t_req)     in
//   result    o_valid (one cycle)   o_rsp  (t_rsp)     out
//
// A submit walks the stored entries once with a single signed comparator.
// When the table is full, one extra read of the last entry first decides
// whether the entry qualifies, and a full table turns a non-qualifying entry
// away without a walk. A read waits on one RAM read; clear and the unused
// command answer without going busy.
// Reset clears the state, the result strobe and the fill count; the entry
// store needs no clearing pass, since only entries below the count are ever used.
// The result strobe cannot be stalled; busy drops in the cycle it shows, so
// the next request may start while a result is on the ports.
module bounded_top_k_sorted_insert #(
    parameter int CAPACITY = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  btk_pkg::t_req i_req,
    output logic          o_valid,
    output btk_pkg::t_rsp o_rsp
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = $bits(btk_pkg::t_entry);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LAST,
        S_WALK,
        S_RDATA
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_idx, n_idx;
    btk_pkg::t_entry r_carry, n_carry;
    logic            r_ins, n_ins;
    logic            r_full, n_full;
    logic            r_rd_ok, n_rd_ok;
    logic            r_valid, n_valid;
    btk_pkg::t_rsp   r_rsp, n_rsp;

    // RAM port signals.
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    btk_pkg::t_entry ram_wdata;
    logic [AW-1:0]   ram_raddr;
    btk_pkg::t_entry ram_rdata;

    // Helper views of indexes at common widths.
    logic [AW+2:0]   idx_ext;
    logic [AW:0]     idx_next;
    logic [CW+3:0]   count_ext;
    logic            rd_in_range;

    assign idx_ext     = (AW + 3)'(i_req.read_index);
    assign idx_next    = (AW + 1)'(r_idx) + (AW + 1)'(1);
    assign count_ext   = (CW + 4)'(r_count);
    assign rd_in_range = (32'(i_req.read_index) < 32'(r_count)) &&
                         (32'(i_req.read_index) < CAPACITY);

    btk_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_carry   = r_carry;
        n_ins     = r_ins;
        n_full    = r_full;
        n_rd_ok   = r_rd_ok;
        n_valid   = 1'b0;
        n_rsp     = r_rsp;
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = r_carry;
        ram_raddr = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    unique case (i_req.command)
                        btk_pkg::CMD_SUBMIT: begin
                            n_carry.score = i_req.points;
                            n_carry.tag   = i_req.tag;
                            n_ins         = 1'b0;
                            n_idx         = '0;
                            if (r_count == CW'(CAPACITY)) begin
                                // Full table: fetch the last entry to qualify.
                                n_full    = 1'b1;
                                ram_raddr = AW'(CAPACITY - 1);
                                n_state   = S_LAST;
                            end else begin
                                n_full    = 1'b0;
                                ram_raddr = '0;
                                n_state   = S_WALK;
                            end
                        end
                        btk_pkg::CMD_READ: begin
                            n_rd_ok   = rd_in_range;
                            ram_raddr = rd_in_range ? idx_ext[AW-1:0] : '0;
                            n_state   = S_RDATA;
                        end
                        btk_pkg::CMD_CLEAR: begin
                            n_count = '0;
                            n_valid = 1'b1;
                            n_rsp   = '0;
                        end
                        default: begin
                            // Unused command: report the count, change nothing.
                            n_valid = 1'b1;
                            n_rsp   = '0;
                        end
                    endcase
                end
            end
            S_LAST: begin
                if (r_carry.score > ram_rdata.score) begin
                    ram_raddr = '0;
                    n_state   = S_WALK;
                end else begin
                    n_valid = 1'b1;
                    n_rsp   = '0;
                    n_state = S_IDLE;
                end
            end
            S_WALK: begin
                if (!r_full && (CW'(r_idx) == r_count)) begin
                    // End of the occupied range: the carried entry lands here.
                    ram_we           = 1'b1;
                    n_count          = r_count + CW'(1);
                    n_valid          = 1'b1;
                    n_rsp            = '0;
                    n_rsp.accepted   = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    // Once the insertion point is passed, every entry moves down
                    // by one: the carried entry is written and the old one picked up.
                    if (r_ins || (ram_rdata.score < r_carry.score)) begin
                        ram_we  = 1'b1;
                        n_carry = ram_rdata;
                        n_ins   = 1'b1;
                    end
                    if (r_full && (r_idx == AW'(CAPACITY - 1))) begin
                        // The entry carried out of the last slot drops.
                        n_valid        = 1'b1;
                        n_rsp          = '0;
                        n_rsp.accepted = 1'b1;
                        n_state        = S_IDLE;
                    end else begin
                        n_idx     = idx_next[AW-1:0];
                        ram_raddr = (32'(idx_next) < CAPACITY) ? idx_next[AW-1:0] : '0;
                    end
                end
            end
            S_RDATA: begin
                n_valid = 1'b1;
                n_rsp   = '0;
                if (r_rd_ok) begin
                    n_rsp.entry_valid  = 1'b1;
                    n_rsp.entry_points = ram_rdata.score;
                    n_rsp.entry_tag    = ram_rdata.tag;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
        r_idx   <= n_idx;
        r_carry <= n_carry;
        r_ins   <= n_ins;
        r_full  <= n_full;
        r_rd_ok <= n_rd_ok;
        r_rsp   <= n_rsp;
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;

    // The count register already holds the value after the step when the
    // result shows, so the reported count is taken from it directly.
    always_comb begin
        o_rsp             = r_rsp;
        o_rsp.entry_count = count_ext[3:0];
    end

    // The table never holds more entries than it has slots.
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= CAPACITY)
        else $error("fill count exceeds capacity");

    // A result always frees the block for the next request.
    a_valid_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while busy");

    // Every accepted request either starts work or answers at once.
    a_start_progress : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_valid))
        else $error("request accepted without progress");

    // An accepted submit leaves at least one entry in the table.
    a_accept_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.accepted) |-> (r_count != '0))
        else $error("accepted entry but table empty");

    // A result is either a submit or a read outcome, never both.
    a_rsp_exclusive : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_rsp.accepted && o_rsp.entry_valid))
        else $error("submit and read flags both set");

endmodule

[rtl/btk_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the entry store of the top-K table. No dependencies.
module btk_ram #(
    parameter int  WIDTH = 64,
    parameter int  DEPTH = 8,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
